FILE: design/lav_pkg.sv
// Package for the look-at view matrix unit: payload types, job types, codes and helpers.
`timescale 1ns / 1ps
`default_nettype none
package lav_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;

    typedef logic signed [31:0] q16_t;   // signed Q16.16
    typedef logic signed [17:0] unit_t;  // normalized component, |v| <= 1.0
    typedef logic signed [18:0] uvec_t;  // recomputed up component
    typedef logic signed [32:0] dir_t;   // target - eye, exact

    typedef struct packed {
        q16_t eye_x;
        q16_t eye_y;
        q16_t eye_z;
        q16_t target_x;
        q16_t target_y;
        q16_t target_z;
        q16_t up_x;
        q16_t up_y;
        q16_t up_z;
    } in_t;

    typedef struct packed {
        logic [1:0] row_index;
        q16_t       col0;
        q16_t       col1;
        q16_t       col2;
        q16_t       col3;
        logic       degenerate;
        logic       last_row;
    } out_t;

    // Request handed from the front end to the back end through the queue.
    typedef struct packed {
        q16_t [2:0] eye;
        dir_t [2:0] dir;
        q16_t [2:0] upv;
        logic       pre_degen;  // direction or up already known to be zero
    } job_t;

    // Finished matrix handed to the row emitter.
    typedef struct packed {
        unit_t [2:0] s;
        uvec_t [2:0] u;
        unit_t [2:0] f;
        q16_t  [2:0] tr;
        logic        degen;
    } mat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NABS,
        ST_NSHIFT,
        ST_NSQ,
        ST_NSQRT,
        ST_NDLOAD,
        ST_NDIV,
        ST_OPS,
        ST_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        NS_DIR,
        NS_UP,
        NS_CR
    } norm_sel_t;

    typedef enum logic [2:0] {
        OP_CR,
        OP_UU,
        OP_DS,
        OP_DU,
        OP_DF
    } op_t;

    // Signed Q20.32 value rounded to Q16.16 scale, ties away from zero.
    function automatic logic signed [36:0] round_q16(input logic signed [51:0] p);
        logic [51:0] m;
        logic [35:0] r;
        m = p[51] ? 52'(-p) : 52'(p);
        r = 36'((m + 52'd32768) >> 16);
        return p[51] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    function automatic q16_t sat32(input logic signed [36:0] v);
        if (v > 37'sd2147483647) begin
            return Q16_MAX;
        end
        if (v < -37'sd2147483648) begin
            return Q16_MIN;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/look_at_view_matrix_unit.sv
// Top level of the look-at view matrix unit.
//
// Input channel (in_valid/in_ready/in_data): one request carries eye, target and
// up vectors, signed Q16.16. Output channel (out_valid/out_ready/out_data): each
// request yields four row results, rows 0 to 3, last_row set on row 3.
// Front end registers the request and forms target - eye; a two-entry queue
// decouples it from the back end, which runs three normalizations (iterative
// shift, sum of squares, 32-step square root, three 18-step divisions), the two
// cross products and the three dot products on one shared 32x32 multiplier.
// A zero vector skips the rest of its normalization after the absolute-value step.
// The square-root and divider iterations set the throughput.
// A request reaches row 0 through the front register, the queue, the back end
// and the row register. Rows then go out one per cycle while out_ready is high.
// The front end keeps accepting up to three requests while the back end works.
// Reset (rst_n, async, active low) empties front, queue and row register and
// idles the back end. A stalled receiver holds the current row steady; the
// back end parks its finished matrix until the row register frees up.
`timescale 1ns / 1ps
`default_nettype none
module look_at_view_matrix_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lav_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lav_pkg::out_t      out_data
);

    logic          fq_valid;
    logic          fq_ready;
    lav_pkg::job_t fq_job;
    logic          qb_valid;
    logic          qb_ready;
    lav_pkg::job_t qb_job;
    logic          br_valid;
    logic          br_ready;
    lav_pkg::mat_t br_mat;

    lav_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    lav_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_job)
    );

    lav_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .mat_valid (br_valid),
        .mat_ready (br_ready),
        .mat       (br_mat)
    );

    lav_rows u_rows (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (br_valid),
        .mat_ready (br_ready),
        .mat       (br_mat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

FILE: design/lav_front.sv
// Front end: takes input requests, forms the view direction and flags zero vectors.
`timescale 1ns / 1ps
`default_nettype none
module lav_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire lav_pkg::in_t in_data,
    output logic              job_valid,
    input  wire logic         job_ready,
    output lav_pkg::job_t     job
);

    logic          full_reg;
    lav_pkg::job_t job_reg;
    lav_pkg::job_t job_next;

    assign in_ready  = !full_reg || job_ready;
    assign job_valid = full_reg;
    assign job       = job_reg;

    always_comb
    begin
        job_next.eye[0] = in_data.eye_x;
        job_next.eye[1] = in_data.eye_y;
        job_next.eye[2] = in_data.eye_z;
        job_next.upv[0] = in_data.up_x;
        job_next.upv[1] = in_data.up_y;
        job_next.upv[2] = in_data.up_z;
        job_next.dir[0] = 33'(in_data.target_x) - 33'(in_data.eye_x);
        job_next.dir[1] = 33'(in_data.target_y) - 33'(in_data.eye_y);
        job_next.dir[2] = 33'(in_data.target_z) - 33'(in_data.eye_z);
        job_next.pre_degen =
            (in_data.target_x == in_data.eye_x && in_data.target_y == in_data.eye_y &&
             in_data.target_z == in_data.eye_z) ||
            (in_data.up_x == '0 && in_data.up_y == '0 && in_data.up_z == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            full_reg <= 1'b1;
        end
        else if (job_ready)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            job_reg <= job_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/lav_queue.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module lav_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire lav_pkg::job_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output lav_pkg::job_t      pop_data
);

    localparam int PTR_W = (lav_pkg::QUEUE_DEPTH > 1) ? $clog2(lav_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lav_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(lav_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(lav_pkg::QUEUE_DEPTH);

    lav_pkg::job_t    mem_reg [lav_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: design/lav_back.sv
// Back end: normalizations, cross products and dot products on one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module lav_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire lav_pkg::job_t job,
    output logic               mat_valid,
    input  wire logic          mat_ready,
    output lav_pkg::mat_t      mat
);

    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;
    localparam logic [4:0]  DIV_LAST  = 5'd17;

    lav_pkg::back_state_t state_reg, state_next;
    lav_pkg::norm_sel_t   nsel_reg;
    lav_pkg::op_t         op_reg;

    lav_pkg::q16_t        eye_reg [3];
    lav_pkg::q16_t        upv_reg [3];
    logic signed [34:0]   nv_reg  [3];
    logic [34:0]          mag_reg [3];
    logic [2:0]           neg_reg;
    lav_pkg::unit_t       f_reg   [3];
    lav_pkg::unit_t       un_reg  [3];
    lav_pkg::unit_t       s_reg   [3];
    lav_pkg::uvec_t       u_reg   [3];
    lav_pkg::q16_t        tr_reg  [3];
    logic                 degen_reg;

    logic [63:0]          sum_reg;
    logic [63:0]          x_reg;
    logic [63:0]          res_reg;
    logic [63:0]          bit_reg;
    logic [31:0]          len_reg;
    logic [31:0]          rem_reg;
    logic [17:0]          dlo_reg;
    logic [17:0]          q_reg;
    logic [4:0]           cnt_reg;
    logic [1:0]           idx_reg;
    logic [1:0]           term_reg;
    logic                 phase_reg;
    logic signed [63:0]   prod_reg;
    logic signed [51:0]   acc_reg;

    logic                 all_zero;
    logic                 mag_hi;
    logic                 mag_lo;
    logic [63:0]          trial;
    logic                 sq_ge;
    logic [63:0]          res_next;
    logic [47:0]          dvd;
    logic [32:0]          dtrial;
    logic                 d_ge;
    logic [17:0]          q_next;
    lav_pkg::unit_t       unit_q;
    logic [1:0]           c1;
    logic [1:0]           c2;
    logic signed [31:0]   mul_a;
    logic signed [31:0]   mul_b;
    logic                 last_term;
    logic                 last_comp;
    logic                 grp_end;
    logic signed [51:0]   acc_sum;
    logic signed [36:0]   rnd;
    logic                 norm_end;

    // ---------------- shared arithmetic ----------------
    always_comb
    begin
        all_zero = nv_reg[0] == '0 && nv_reg[1] == '0 && nv_reg[2] == '0;
        mag_hi   = |{mag_reg[0][34:31], mag_reg[1][34:31], mag_reg[2][34:31]};
        mag_lo   = ~|{mag_reg[0][34:30], mag_reg[1][34:30], mag_reg[2][34:30]};

        trial    = res_reg + bit_reg;
        sq_ge    = x_reg >= trial;
        res_next = sq_ge ? (res_reg >> 1) + bit_reg : res_reg >> 1;

        dvd      = 48'({mag_reg[idx_reg][30:0], 16'h0000}) + 48'(len_reg[31:1]);
        dtrial   = {rem_reg, dlo_reg[17]};
        d_ge     = dtrial >= {1'b0, len_reg};
        q_next   = {q_reg[16:0], d_ge};
        unit_q   = neg_reg[idx_reg] ? -$signed({1'b0, q_next[16:0]})
                                    : $signed({1'b0, q_next[16:0]});

        c1 = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
        c2 = (idx_reg == 2'd0) ? 2'd2 : idx_reg - 2'd1;

        mul_a = '0;
        mul_b = '0;
        if (state_reg == lav_pkg::ST_NSQ)
        begin
            mul_a = $signed({1'b0, mag_reg[idx_reg][30:0]});
            mul_b = $signed({1'b0, mag_reg[idx_reg][30:0]});
        end
        else
        begin
            unique case (op_reg)
                lav_pkg::OP_CR:
                begin
                    mul_a = (term_reg == 2'd0) ? 32'(f_reg[c1]) : -32'(f_reg[c2]);
                    mul_b = (term_reg == 2'd0) ? 32'(un_reg[c2]) : 32'(un_reg[c1]);
                end
                lav_pkg::OP_UU:
                begin
                    mul_a = (term_reg == 2'd0) ? 32'(s_reg[c1]) : -32'(s_reg[c2]);
                    mul_b = (term_reg == 2'd0) ? 32'(f_reg[c2]) : 32'(f_reg[c1]);
                end
                lav_pkg::OP_DS:
                begin
                    mul_a = 32'(s_reg[term_reg]);
                    mul_b = eye_reg[term_reg];
                end
                lav_pkg::OP_DU:
                begin
                    mul_a = 32'(u_reg[term_reg]);
                    mul_b = eye_reg[term_reg];
                end
                lav_pkg::OP_DF:
                begin
                    mul_a = 32'(f_reg[term_reg]);
                    mul_b = eye_reg[term_reg];
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end

        last_term = (op_reg == lav_pkg::OP_CR || op_reg == lav_pkg::OP_UU)
                    ? term_reg == 2'd1 : term_reg == 2'd2;
        last_comp = (op_reg == lav_pkg::OP_CR || op_reg == lav_pkg::OP_UU)
                    ? idx_reg == 2'd2 : 1'b1;
        grp_end   = state_reg == lav_pkg::ST_OPS && phase_reg && last_term;
        acc_sum   = acc_reg + $signed(prod_reg[51:0]);
        rnd       = lav_pkg::round_q16(acc_sum);

        norm_end  = (state_reg == lav_pkg::ST_NABS && all_zero) ||
                    (state_reg == lav_pkg::ST_NDIV && cnt_reg == DIV_LAST && idx_reg == 2'd2);
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lav_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_ready  = 1'b0;
        mat_valid  = 1'b0;
        unique case (state_reg)
            lav_pkg::ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    state_next = lav_pkg::ST_NABS;
                end
            end
            lav_pkg::ST_NABS:
            begin
                if (!all_zero)
                begin
                    state_next = lav_pkg::ST_NSHIFT;
                end
                else if (nsel_reg == lav_pkg::NS_DIR)
                begin
                    state_next = lav_pkg::ST_NABS;
                end
                else
                begin
                    state_next = lav_pkg::ST_OPS;
                end
            end
            lav_pkg::ST_NSHIFT:
            begin
                if (!mag_hi && !mag_lo)
                begin
                    state_next = lav_pkg::ST_NSQ;
                end
            end
            lav_pkg::ST_NSQ:
            begin
                if (phase_reg && idx_reg == 2'd2)
                begin
                    state_next = lav_pkg::ST_NSQRT;
                end
            end
            lav_pkg::ST_NSQRT:
            begin
                if (bit_reg[0])
                begin
                    state_next = lav_pkg::ST_NDLOAD;
                end
            end
            lav_pkg::ST_NDLOAD:
            begin
                state_next = lav_pkg::ST_NDIV;
            end
            lav_pkg::ST_NDIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    if (idx_reg != 2'd2)
                    begin
                        state_next = lav_pkg::ST_NDLOAD;
                    end
                    else if (nsel_reg == lav_pkg::NS_DIR)
                    begin
                        state_next = lav_pkg::ST_NABS;
                    end
                    else
                    begin
                        state_next = lav_pkg::ST_OPS;
                    end
                end
            end
            lav_pkg::ST_OPS:
            begin
                if (grp_end && last_comp)
                begin
                    if (op_reg == lav_pkg::OP_CR)
                    begin
                        state_next = lav_pkg::ST_NABS;
                    end
                    else if (op_reg == lav_pkg::OP_DF)
                    begin
                        state_next = lav_pkg::ST_DONE;
                    end
                end
            end
            lav_pkg::ST_DONE:
            begin
                mat_valid = 1'b1;
                if (mat_ready)
                begin
                    state_next = lav_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lav_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        unique case (state_reg)
            lav_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        eye_reg[i] <= job.eye[i];
                        upv_reg[i] <= job.upv[i];
                        nv_reg[i]  <= 35'(job.dir[i]);
                    end
                    nsel_reg  <= lav_pkg::NS_DIR;
                    degen_reg <= job.pre_degen;
                end
            end
            lav_pkg::ST_NABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= nv_reg[i][34];
                    mag_reg[i] <= nv_reg[i][34] ? 35'(-nv_reg[i]) : 35'(nv_reg[i]);
                end
                if (all_zero)
                begin
                    degen_reg <= 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        unique case (nsel_reg)
                            lav_pkg::NS_DIR: f_reg[i]  <= '0;
                            lav_pkg::NS_UP:  un_reg[i] <= '0;
                            lav_pkg::NS_CR:  s_reg[i]  <= '0;
                            default:         s_reg[i]  <= '0;
                        endcase
                    end
                end
            end
            lav_pkg::ST_NSHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mag_hi)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (mag_lo)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
                idx_reg   <= 2'd0;
                phase_reg <= 1'b0;
                sum_reg   <= '0;
            end
            lav_pkg::ST_NSQ:
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    sum_reg <= sum_reg + $unsigned(prod_reg);
                    idx_reg <= idx_reg + 2'd1;
                    x_reg   <= sum_reg + $unsigned(prod_reg);
                    res_reg <= '0;
                    bit_reg <= SQRT_BIT0;
                end
            end
            lav_pkg::ST_NSQRT:
            begin
                if (sq_ge)
                begin
                    x_reg <= x_reg - trial;
                end
                res_reg <= res_next;
                bit_reg <= bit_reg >> 2;
                len_reg <= res_next[31:0];
                idx_reg <= 2'd0;
            end
            lav_pkg::ST_NDLOAD:
            begin
                rem_reg <= 32'(dvd[47:18]);
                dlo_reg <= dvd[17:0];
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            lav_pkg::ST_NDIV:
            begin
                rem_reg <= d_ge ? 32'(dtrial - {1'b0, len_reg}) : dtrial[31:0];
                q_reg   <= q_next;
                dlo_reg <= dlo_reg << 1;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    unique case (nsel_reg)
                        lav_pkg::NS_DIR: f_reg[idx_reg]  <= unit_q;
                        lav_pkg::NS_UP:  un_reg[idx_reg] <= unit_q;
                        lav_pkg::NS_CR:  s_reg[idx_reg]  <= unit_q;
                        default:         s_reg[idx_reg]  <= unit_q;
                    endcase
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            lav_pkg::ST_OPS:
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    acc_reg  <= acc_sum;
                    term_reg <= term_reg + 2'd1;
                end
                if (grp_end)
                begin
                    acc_reg  <= '0;
                    term_reg <= '0;
                    idx_reg  <= last_comp ? 2'd0 : idx_reg + 2'd1;
                    unique case (op_reg)
                        lav_pkg::OP_CR:
                        begin
                            nv_reg[idx_reg] <= acc_sum[34:0];
                            if (last_comp)
                            begin
                                nsel_reg <= lav_pkg::NS_CR;
                            end
                        end
                        lav_pkg::OP_UU:
                        begin
                            u_reg[idx_reg] <= rnd[18:0];
                            if (last_comp)
                            begin
                                op_reg <= lav_pkg::OP_DS;
                            end
                        end
                        lav_pkg::OP_DS:
                        begin
                            tr_reg[0] <= lav_pkg::sat32(-rnd);
                            op_reg    <= lav_pkg::OP_DU;
                        end
                        lav_pkg::OP_DU:
                        begin
                            tr_reg[1] <= lav_pkg::sat32(-rnd);
                            op_reg    <= lav_pkg::OP_DF;
                        end
                        lav_pkg::OP_DF:
                        begin
                            tr_reg[2] <= lav_pkg::sat32(rnd);
                        end
                        default:
                        begin
                            op_reg <= lav_pkg::OP_DF;
                        end
                    endcase
                end
            end
            lav_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // end of a normalization: pick the next piece of work
        if (norm_end)
        begin
            unique case (nsel_reg)
                lav_pkg::NS_DIR:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        nv_reg[i] <= 35'(upv_reg[i]);
                    end
                    nsel_reg <= lav_pkg::NS_UP;
                end
                lav_pkg::NS_UP:
                begin
                    op_reg    <= lav_pkg::OP_CR;
                    idx_reg   <= 2'd0;
                    term_reg  <= 2'd0;
                    phase_reg <= 1'b0;
                    acc_reg   <= '0;
                end
                lav_pkg::NS_CR:
                begin
                    op_reg    <= lav_pkg::OP_UU;
                    idx_reg   <= 2'd0;
                    term_reg  <= 2'd0;
                    phase_reg <= 1'b0;
                    acc_reg   <= '0;
                end
                default:
                begin
                    op_reg <= lav_pkg::OP_UU;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mat.s[i]  = s_reg[i];
            mat.u[i]  = u_reg[i];
            mat.f[i]  = f_reg[i];
            mat.tr[i] = tr_reg[i];
        end
        mat.degen = degen_reg;
    end

endmodule
`default_nettype wire

FILE: design/lav_rows.sv
// Row emitter: holds one finished matrix and sends it out as four row results.
`timescale 1ns / 1ps
`default_nettype none
module lav_rows (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          mat_valid,
    output logic               mat_ready,
    input  wire lav_pkg::mat_t mat,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lav_pkg::out_t      out_data
);

    localparam logic [1:0] LAST_ROW = 2'd3;

    lav_pkg::mat_t mat_reg;
    logic          full_reg;
    logic [1:0]    row_reg;
    logic          row_done;

    assign out_valid = full_reg;
    assign row_done  = full_reg && out_ready;
    assign mat_ready = !full_reg || (row_done && row_reg == LAST_ROW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            row_reg  <= '0;
        end
        else if (mat_valid && mat_ready)
        begin
            full_reg <= 1'b1;
            row_reg  <= '0;
        end
        else if (row_done)
        begin
            row_reg <= row_reg + 2'd1;
            if (row_reg == LAST_ROW)
            begin
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mat_valid && mat_ready)
        begin
            mat_reg <= mat;
        end
    end

    always_comb
    begin
        out_data.row_index  = row_reg;
        out_data.degenerate = mat_reg.degen;
        out_data.last_row   = row_reg == LAST_ROW;
        unique case (row_reg)
            2'd0:
            begin
                out_data.col0 = 32'(mat_reg.s[0]);
                out_data.col1 = 32'(mat_reg.s[1]);
                out_data.col2 = 32'(mat_reg.s[2]);
                out_data.col3 = mat_reg.tr[0];
            end
            2'd1:
            begin
                out_data.col0 = 32'(mat_reg.u[0]);
                out_data.col1 = 32'(mat_reg.u[1]);
                out_data.col2 = 32'(mat_reg.u[2]);
                out_data.col3 = mat_reg.tr[1];
            end
            2'd2:
            begin
                out_data.col0 = -32'(mat_reg.f[0]);
                out_data.col1 = -32'(mat_reg.f[1]);
                out_data.col2 = -32'(mat_reg.f[2]);
                out_data.col3 = mat_reg.tr[2];
            end
            default:
            begin
                out_data.col0 = '0;
                out_data.col1 = '0;
                out_data.col2 = '0;
                out_data.col3 = lav_pkg::ONE_Q16;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/lav_checker.sv
// Port checker for the look-at view matrix unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lav_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire lav_pkg::out_t out_data
);

    logic [1:0] exp_row_reg;
    logic       deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_row_reg <= '0;
            deg_reg     <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            exp_row_reg <= out_data.row_index + 2'd1;
            if (out_data.row_index == 2'd0)
            begin
                deg_reg <= out_data.degenerate;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("row result changed while stalled");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.row_index == exp_row_reg)
        else $error("row results out of order");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.last_row == (out_data.row_index == 2'd3))
        else $error("last_row does not match row 3");

    a_row3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.row_index == 2'd3 |->
            out_data.col0 == 32'sd0 && out_data.col1 == 32'sd0 &&
            out_data.col2 == 32'sd0 && out_data.col3 == 32'sd65536)
        else $error("bottom row is not 0 0 0 1");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.row_index != 2'd0 |-> out_data.degenerate == deg_reg)
        else $error("degenerate flag changed within a matrix");

endmodule

bind look_at_view_matrix_unit lav_checker u_lav_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_look_at_view_matrix_unit.sv
// Testbench for the look-at view matrix unit: directed and random camera requests.
`timescale 1ns / 1ps
module tb_look_at_view_matrix_unit;

    typedef longint vec3_t [3];

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    lav_pkg::in_t  in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    lav_pkg::out_t out_data;

    // Rows still owed by the block, oldest first.
    lav_pkg::out_t pending_rows[$];
    int   error_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    look_at_view_matrix_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // View matrix predictor
    // ---------------------------------------------------------------

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Scale largest magnitude into [2^30, 2^31), then divide by the length.
    // Returns 0 for a zero vector, which stays zero.
    function automatic bit unit_vector(input vec3_t v, output vec3_t n);
        longint unsigned mag[3];
        longint unsigned m;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
        begin
            n[0] = 0;
            n[1] = 0;
            n[2] = 0;
            return 1'b0;
        end
        while (m >= (64'd1 << 31))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 30))
        begin
            m = m << 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] << 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++)
            sum = sum + mag[i] * mag[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << 16) + (len >> 1)) / len;
            n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    // Q32.32 back to Q16.16, ties away from zero.
    function automatic longint to_q16(input longint p);
        longint unsigned m;
        m = p < 0 ? longint'(-p) : longint'(p);
        m = (m + 64'd32768) >> 16;
        return p < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic lav_pkg::q16_t clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return lav_pkg::Q16_MAX;
        if (v < -64'sd2147483648)
            return lav_pkg::Q16_MIN;
        return lav_pkg::q16_t'(v);
    endfunction

    function automatic void predict_view_rows(input lav_pkg::in_t r);
        vec3_t eye, dir, upv, f, un, cr, s, u;
        bit    ok;
        lav_pkg::out_t row;
        longint ds, du, df;
        eye[0] = longint'(r.eye_x);
        eye[1] = longint'(r.eye_y);
        eye[2] = longint'(r.eye_z);
        dir[0] = longint'(r.target_x) - eye[0];
        dir[1] = longint'(r.target_y) - eye[1];
        dir[2] = longint'(r.target_z) - eye[2];
        upv[0] = longint'(r.up_x);
        upv[1] = longint'(r.up_y);
        upv[2] = longint'(r.up_z);
        ok = unit_vector(dir, f);
        ok = unit_vector(upv, un) & ok;
        cr[0] = f[1] * un[2] - f[2] * un[1];
        cr[1] = f[2] * un[0] - f[0] * un[2];
        cr[2] = f[0] * un[1] - f[1] * un[0];
        ok = unit_vector(cr, s) & ok;
        u[0] = to_q16(s[1] * f[2] - s[2] * f[1]);
        u[1] = to_q16(s[2] * f[0] - s[0] * f[2]);
        u[2] = to_q16(s[0] * f[1] - s[1] * f[0]);
        ds = -to_q16(s[0] * eye[0] + s[1] * eye[1] + s[2] * eye[2]);
        du = -to_q16(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]);
        df = to_q16(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]);
        for (int k = 0; k < 4; k++)
        begin
            row.row_index = 2'(k);
            row.degenerate = ~ok;
            row.last_row = (k == 3);
            case (k)
                0:
                begin
                    row.col0 = clamp_q16(s[0]);
                    row.col1 = clamp_q16(s[1]);
                    row.col2 = clamp_q16(s[2]);
                    row.col3 = clamp_q16(ds);
                end
                1:
                begin
                    row.col0 = clamp_q16(u[0]);
                    row.col1 = clamp_q16(u[1]);
                    row.col2 = clamp_q16(u[2]);
                    row.col3 = clamp_q16(du);
                end
                2:
                begin
                    row.col0 = clamp_q16(-f[0]);
                    row.col1 = clamp_q16(-f[1]);
                    row.col2 = clamp_q16(-f[2]);
                    row.col3 = clamp_q16(df);
                end
                default:
                begin
                    row.col0 = '0;
                    row.col1 = '0;
                    row.col2 = '0;
                    row.col3 = lav_pkg::ONE_Q16;
                end
            endcase
            pending_rows.push_back(row);
        end
    endfunction

    // ---------------------------------------------------------------
    // Request driver: called at a rising edge, returns at the accepting edge.
    // in_valid stays high into the next request unless an idle gap is drawn.
    // ---------------------------------------------------------------
    task automatic send_request(input lav_pkg::in_t req);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        predict_view_rows(req);
    endtask

    function automatic lav_pkg::in_t make_request(input lav_pkg::q16_t ex, ey, ez,
                                                  tx, ty, tz, ux, uy, uz);
        lav_pkg::in_t r;
        r.eye_x = ex;
        r.eye_y = ey;
        r.eye_z = ez;
        r.target_x = tx;
        r.target_y = ty;
        r.target_z = tz;
        r.up_x = ux;
        r.up_y = uy;
        r.up_z = uz;
        return r;
    endfunction

    // Mostly modest coordinates, some full-range words.
    function automatic lav_pkg::q16_t rand_coord();
        case ($urandom_range(3))
            0: return lav_pkg::q16_t'($urandom);
            1: return lav_pkg::q16_t'($signed($urandom_range(0, 32'h003F_FFFF))
                                      - 32'sh0020_0000);
            2: return lav_pkg::q16_t'($signed($urandom_range(0, 32'h0FFF_FFFF))
                                      - 32'sh0800_0000);
            default: return lav_pkg::q16_t'($signed($urandom_range(0, 255)) - 128);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Response side: random stall, in-order compare
    // ---------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic compare_field(input string name, input longint exp_v, act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rows.size() == 0)
            begin
                $display("%0t: unexpected row, expected none, got %p", $time, out_data);
                error_count++;
            end
            else
            begin
                lav_pkg::out_t exp_row;
                exp_row = pending_rows.pop_front();
                compare_field("row_index", exp_row.row_index, out_data.row_index);
                compare_field("col0", exp_row.col0, out_data.col0);
                compare_field("col1", exp_row.col1, out_data.col1);
                compare_field("col2", exp_row.col2, out_data.col2);
                compare_field("col3", exp_row.col3, out_data.col3);
                compare_field("degenerate", exp_row.degenerate, out_data.degenerate);
                compare_field("last_row", exp_row.last_row, out_data.last_row);
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Canonical camera, extremes, saturating translation and degenerate cases.
    task automatic test_directed();
        lav_pkg::q16_t one;
        lav_pkg::q16_t hi;
        lav_pkg::q16_t lo;
        one = lav_pkg::ONE_Q16;
        hi  = lav_pkg::Q16_MAX;
        lo  = lav_pkg::Q16_MIN;
        // eye on +z looking at origin, y up
        send_request(make_request(0, 0, 5 * one, 0, 0, 0, 0, one, 0));
        send_request(make_request(one, 2 * one, 3 * one, -one, 0, one, 0, 0, one));
        // eye equal to target: zero direction
        send_request(make_request(one, one, one, one, one, one, 0, one, 0));
        // zero up vector
        send_request(make_request(0, 0, 0, one, one, 0, 0, 0, 0));
        // up parallel and anti-parallel to the direction
        send_request(make_request(0, 0, 0, 0, 0, one, 0, 0, 7 * one));
        send_request(make_request(0, 0, 0, 3, 3, 0, -5, -5, 0));
        // everything zero
        send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // field extremes, widest direction
        send_request(make_request(hi, hi, hi, lo, lo, lo, lo, hi, lo));
        send_request(make_request(lo, lo, hi, hi, hi, lo, hi, hi, hi));
        // far eye: translation terms saturate both ways
        send_request(make_request(hi, lo, hi, 0, 0, 0, 0, one, 0));
        send_request(make_request(lo, hi, lo, 0, 0, 0, one, 0, one));
        // one-lsb vectors stretch the scaling
        send_request(make_request(0, 0, 0, 1, 0, 0, 0, -1, 0));
        send_request(make_request(-1, -1, -1, 0, 0, 0, 1, 1, -1));
        send_request(make_request(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F,
                                  32'shF0F0_F0F0, 32'sh3333_3333, 32'shCCCC_CCCC,
                                  32'sh1234_5678, 32'shEDCB_A987, 32'sh7F00_00FF));
    endtask

    task automatic test_random(input int count);
        lav_pkg::in_t r;
        repeat (count)
        begin
            r = make_request(rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord());
            case ($urandom_range(19))
                0:
                begin
                    r.target_x = r.eye_x;
                    r.target_y = r.eye_y;
                    r.target_z = r.eye_z;
                end
                1:
                begin
                    r.up_x = '0;
                    r.up_y = '0;
                    r.up_z = '0;
                end
                2:
                begin
                    // up along the viewing direction
                    r.target_x = lav_pkg::q16_t'($signed($urandom_range(0, 2000)) - 1000);
                    r.target_y = lav_pkg::q16_t'($signed($urandom_range(0, 2000)) - 1000);
                    r.target_z = lav_pkg::q16_t'($signed($urandom_range(0, 2000)) - 1000);
                    r.eye_x = '0;
                    r.eye_y = '0;
                    r.eye_z = '0;
                    r.up_x = r.target_x * 3;
                    r.up_y = r.target_y * 3;
                    r.up_z = r.target_z * 3;
                end
                default:
                begin
                end
            endcase
            send_request(r);
        end
    endtask

    task automatic wait_for_drain();
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 53;
        test_directed();
        test_random(160);

        send_idle_pct = 53;
        recv_idle_pct = 13;
        test_random(160);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(170);

        in_valid <= 1'b0;
        wait_for_drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: a time limit far beyond what ~500 requests need.
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
